// ===== design/spc_pkg.sv =====
// Shared types and constants of the serial pad port controller.
`default_nettype none
package spc_pkg;

   // bus function codes carried in the request tuser
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;

   // register offsets within the block
   localparam logic [3:0] OFF_DATA    = 4'd0;
   localparam logic [3:0] OFF_STATUS  = 4'd4;
   localparam logic [3:0] OFF_MODE    = 4'd8;
   localparam logic [3:0] OFF_CONTROL = 4'd10;
   localparam logic [3:0] OFF_BAUD    = 4'd14;

   // access widths
   localparam logic [1:0] WID_BYTE = 2'd0;
   localparam logic [1:0] WID_HALF = 2'd1;
   localparam logic [1:0] WID_WORD = 2'd2;

   // control write bits
   localparam int CTRL_ACK_BIT   = 4;
   localparam int CTRL_RESET_BIT = 6;

   // internal control bit positions
   localparam int CB_TX_EN    = 0;
   localparam int CB_OUTPUT   = 1;
   localparam int CB_RX_IRQ   = 6;
   localparam int CB_PORT_SEL = 8;

   localparam logic [7:0] EMPTY_BYTE = 8'hff;

   // result kinds
   localparam logic KIND_BIT  = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_READ,
      OP_WRITE,
      OP_NONE
   } op_type;

   // classified item handed from front to back
   typedef struct packed {
      op_type      op;
      logic [3:0]  reg_offset;
      logic [1:0]  access_width;
      logic [15:0] write_data;
      logic [9:0]  tick_amount;
      logic        rx_line;
      logic        dsr_low;
   } item_type;

   // control register as seen on a bus read
   function automatic logic [15:0] ctrl_read(input logic [8:0] c);
      ctrl_read = {2'b00, c[8], c[7], c[6], c[5], c[4:3], 5'b00000, c[2:0]};
   endfunction

   // control register from bus write data
   function automatic logic [8:0] ctrl_write(input logic [15:0] d);
      ctrl_write = {d[13], d[12], d[11], d[10], d[9:8], d[2:0]};
   endfunction

endpackage
`default_nettype wire

// ===== design/spc_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module spc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]             wr_data,
   input  wire  [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/spc_front.sv =====
// Front end: accepts request beats, classifies them and queues them for the engine.
`default_nettype none
module spc_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire  [39:0]       req_tdata,
   input  wire  [1:0]        req_tuser,
   output logic              item_valid,
   input  wire               item_pop,
   output spc_pkg::item_type item
);
   import spc_pkg::*;

   item_type  slot_ff [2];
   logic [1:0] count_ff;
   logic       rd_ptr_ff;
   logic       wr_ptr_ff;
   item_type   incoming;
   logic       push;

   // classify the beat
   always_comb begin
      unique case (req_tuser)
         FUNC_TICK:  incoming.op = OP_TICK;
         FUNC_READ:  incoming.op = OP_READ;
         FUNC_WRITE: incoming.op = OP_WRITE;
         default:    incoming.op = OP_NONE;
      endcase
      incoming.reg_offset   = req_tdata[3:0];
      incoming.access_width = req_tdata[5:4];
      incoming.write_data   = req_tdata[21:6];
      incoming.tick_amount  = req_tdata[31:22];
      incoming.rx_line      = req_tdata[32];
      incoming.dsr_low      = req_tdata[33];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   // two-entry queue
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            slot_ff[wr_ptr_ff] <= incoming;
            wr_ptr_ff          <= ~wr_ptr_ff;
         end
         if (item_pop && item_valid) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(item_pop && item_valid);
      end
   end
endmodule
`default_nettype wire

// ===== design/spc_back.sv =====
// Back end: register file, baud loop, shifter, rx queue and result register.
`default_nettype none
module spc_back #(
   parameter int RX_DEPTH = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               item_valid,
   output logic              item_pop,
   input  spc_pkg::item_type item,
   input  wire  [6:0]        baud_factor,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [23:0]       rsp_tdata,   // tx_bit, read_data, unhandled, irq_raised, dtr0, dtr1
   output logic              rsp_tuser,   // kind
   output logic              rsp_tlast
);
   import spc_pkg::*;

   localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int CW = $clog2(RX_DEPTH + 1);
   localparam int SW = CW + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOP,
      ST_RDWAIT,
      ST_DONE
   } state_type;

   state_type     state_ff;
   item_type      cur_ff;
   logic [7:0]    tx_shift_ff;
   logic          tx_busy_ff;
   logic [2:0]    bit_index_ff;
   logic [7:0]    rx_shift_ff;
   logic [CW-1:0] rx_count_ff;
   logic [AW-1:0] rx_head_ff;
   logic [23:0]   baud_count_ff;
   logic          dsr_level_ff;
   logic          irq_ff;
   logic          irq_before_ff;
   logic [8:0]    ctrl_ff;
   logic [15:0]   reload_ff;
   logic [1:0]    dtr_ff;
   logic signed [24:0] cnt_ff;
   logic [22:0]   period_ff;
   logic [15:0]   rd_ff;
   logic          unh_ff;
   logic          out_valid_ff;
   logic [20:0]   out_data_ff;
   logic          out_kind_ff;
   logic          out_last_ff;

   logic          out_free;
   logic          out_load;
   logic          cnt_le0;
   logic          do_bit;
   logic          byte_done;
   logic [7:0]    rx_next;
   logic [SW-1:0] tail_sum;
   logic [AW-1:0] tail;
   logic          ram_we;
   logic [7:0]    ram_rdata;
   logic          is_half;
   logic          pop_byte;
   logic [15:0]   reload_eff;
   logic [6:0]    factor_eff;
   logic [15:0]   status_word;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign cnt_le0   = cnt_ff[24] || (cnt_ff == 25'sd0);
   assign do_bit    = ctrl_ff[CB_TX_EN] && tx_busy_ff;
   assign byte_done = (bit_index_ff == 3'd7);
   assign is_half   = (item.access_width == WID_HALF) || (item.access_width == WID_WORD);
   assign item_pop  = (state_ff == ST_IDLE);

   // a beat enters the result register on a shifted bit or a completion
   assign out_load = out_free && (((state_ff == ST_LOOP) && cnt_le0 && do_bit)
                                  || (state_ff == ST_DONE));

   // receive byte with the current bit filled in
   always_comb begin
      rx_next               = rx_shift_ff;
      rx_next[bit_index_ff] = cur_ff.rx_line;
   end

   // tail of the rx queue, one wrap at most
   always_comb begin
      tail_sum = SW'(rx_head_ff) + SW'(rx_count_ff);
      if (tail_sum >= SW'(RX_DEPTH)) begin
         tail_sum = tail_sum - SW'(RX_DEPTH);
      end
      tail = tail_sum[AW-1:0];
   end

   assign ram_we = (state_ff == ST_LOOP) && cnt_le0 && do_bit && out_free && byte_done
                   && (rx_count_ff < CW'(RX_DEPTH));

   assign pop_byte = (item.op == OP_READ) && (item.access_width == WID_BYTE)
                     && (item.reg_offset == OFF_DATA) && (rx_count_ff != '0);

   assign reload_eff = (reload_ff == 16'd0) ? 16'd1 : reload_ff;
   assign factor_eff = (baud_factor == 7'd0) ? 7'd1 : baud_factor;

   // status: tx idle, rx not empty, one, dsr at bit 7, irq at bit 9, baud count on top
   assign status_word = {baud_count_ff[4:0], 1'b0, irq_ff, 1'b0, dsr_level_ff, 5'b00001,
                         (rx_count_ff != '0), !tx_busy_ff};

   spc_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail),
      .wr_data (rx_next),
      .rd_addr (rx_head_ff),
      .rd_data (ram_rdata)
   );

   // engine state machine and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tx_shift_ff   <= 8'd0;
         tx_busy_ff    <= 1'b0;
         bit_index_ff  <= 3'd0;
         rx_shift_ff   <= 8'd0;
         rx_count_ff   <= '0;
         rx_head_ff    <= '0;
         baud_count_ff <= 24'd0;
         dsr_level_ff  <= 1'b1;
         irq_ff        <= 1'b0;
         ctrl_ff       <= 9'd0;
         reload_ff     <= 16'd0;
         dtr_ff        <= 2'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_load || (out_valid_ff && !rsp_tready);
         unique case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  cur_ff        <= item;
                  irq_before_ff <= irq_ff;
                  rd_ff         <= 16'd0;
                  unh_ff        <= 1'b0;
                  state_ff      <= ST_DONE;
                  unique case (item.op)
                     OP_TICK: begin
                        cnt_ff    <= $signed({1'b0, baud_count_ff})
                                     - $signed({15'd0, item.tick_amount});
                        period_ff <= reload_eff * factor_eff;
                        state_ff  <= ST_LOOP;
                     end
                     OP_READ: begin
                        if (pop_byte) begin
                           rx_head_ff  <= (rx_head_ff == AW'(RX_DEPTH - 1)) ? '0
                                          : rx_head_ff + AW'(1);
                           rx_count_ff <= rx_count_ff - CW'(1);
                           state_ff    <= ST_RDWAIT;
                        end else if (item.access_width == WID_BYTE
                                     && item.reg_offset == OFF_DATA) begin
                           rd_ff <= {8'd0, EMPTY_BYTE};
                        end else if (is_half && item.reg_offset == OFF_STATUS) begin
                           rd_ff <= status_word;
                        end else if (is_half && item.reg_offset == OFF_CONTROL) begin
                           rd_ff <= ctrl_read(ctrl_ff);
                        end else if (is_half && item.reg_offset == OFF_BAUD) begin
                           rd_ff <= reload_ff;
                        end else begin
                           unh_ff <= 1'b1;
                        end
                     end
                     OP_WRITE: begin
                        if (item.access_width == WID_BYTE && item.reg_offset == OFF_DATA) begin
                           tx_shift_ff <= item.write_data[7:0];
                           tx_busy_ff  <= 1'b1;
                        end else if (is_half && item.reg_offset == OFF_MODE) begin
                           unh_ff <= 1'b0;
                        end else if (is_half && item.reg_offset == OFF_CONTROL) begin
                           if (item.write_data[CTRL_RESET_BIT]) begin
                              irq_ff               <= 1'b0;
                              ctrl_ff[CB_OUTPUT]   <= 1'b0;
                              ctrl_ff[CB_PORT_SEL] <= 1'b0;
                              rx_count_ff          <= '0;
                              rx_head_ff           <= '0;
                              dtr_ff               <= 2'd0;
                           end else begin
                              if (item.write_data[CTRL_ACK_BIT]) begin
                                 irq_ff <= 1'b0;
                              end
                              ctrl_ff <= ctrl_write(item.write_data);
                              dtr_ff  <= {item.write_data[1] && item.write_data[13],
                                          item.write_data[1] && !item.write_data[13]};
                           end
                        end else if (is_half && item.reg_offset == OFF_BAUD) begin
                           reload_ff <= item.write_data;
                        end else begin
                           unh_ff <= 1'b1;
                        end
                     end
                     default: begin
                        unh_ff <= 1'b0;
                     end
                  endcase
               end
            end
            // one baud period per cycle; a shifted bit waits for a free result slot
            ST_LOOP: begin
               if (cnt_le0) begin
                  if (!do_bit) begin
                     cnt_ff <= cnt_ff + $signed({2'b00, period_ff});
                  end else if (out_free) begin
                     cnt_ff                    <= cnt_ff + $signed({2'b00, period_ff});
                     tx_shift_ff[bit_index_ff] <= 1'b1;
                     rx_shift_ff               <= rx_next;
                     out_kind_ff  <= KIND_BIT;
                     out_last_ff  <= 1'b0;
                     out_data_ff  <= {dtr_ff[1], dtr_ff[0], 1'b0, 1'b0, 16'd0,
                                      tx_shift_ff[bit_index_ff]};
                     if (byte_done) begin
                        bit_index_ff <= 3'd0;
                        tx_busy_ff   <= 1'b0;
                        if (rx_count_ff < CW'(RX_DEPTH)) begin
                           rx_count_ff <= rx_count_ff + CW'(1);
                        end
                        if (ctrl_ff[CB_RX_IRQ]) begin
                           irq_ff <= 1'b1;
                        end
                     end else begin
                        bit_index_ff <= bit_index_ff + 3'd1;
                     end
                  end
               end else begin
                  baud_count_ff <= cnt_ff[23:0];
                  dsr_level_ff  <= !cur_ff.dsr_low;
                  if (cur_ff.dsr_low) begin
                     irq_ff <= 1'b1;
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_RDWAIT: begin
               rd_ff    <= {8'd0, ram_rdata};
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  out_kind_ff  <= KIND_DONE;
                  out_last_ff  <= 1'b1;
                  out_data_ff  <= {dtr_ff[1], dtr_ff[0], !irq_before_ff && irq_ff,
                                   unh_ff, rd_ff, 1'b0};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_data_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
endmodule
`default_nettype wire

// ===== design/serial_pad_port_controller.sv =====
// Order: a read or write passes ST_DONE (a popped rx byte ST_RDWAIT first) to the result
// beat; a tick runs ST_LOOP over each expired baud period, each shifted bit one beat.
// Throughput: one engine item at a time; the baud loop takes one period a cycle unless
// a bit awaits output; the two-entry queue and result register decouple both sides.
// Reset: synchronous, active high; state clears, DSR reads high, baud factor returns to 1,
// rx queue contents stay undefined.
`default_nettype none
module serial_pad_port_controller #(
   parameter int RX_DEPTH = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // reg_offset, access_width, write_data, tick_amount,
                                    // rx_line, dsr_low
   input  wire  [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // tx_bit, read_data, unhandled, irq_raised, dtr_port0,
                                    // dtr_port1
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import spc_pkg::*;

   logic       item_valid;
   logic       item_pop;
   item_type   item;
   logic [6:0] baud_factor_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {25'd0, baud_factor_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         baud_factor_ff <= 7'd1;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         baud_factor_ff <= csr_pwdata[6:0];
      end
   end

   spc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   spc_back #(.RX_DEPTH(RX_DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_pop    (item_pop),
      .item        (item),
      .baud_factor (baud_factor_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );
endmodule
`default_nettype wire
